FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// every checked module provides clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/nsps_pkg.sv
// ----------------------------------------------------------------------------
// nsps_pkg
// Shared types and constants of the nucleotide stream packer and segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package nsps_pkg;

	// result kinds
	localparam logic [1:0] KIND_BASE    = 2'd0;
	localparam logic [1:0] KIND_PIECE   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// input actions
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// character codes
	localparam logic [7:0] CHAR_HEADER    = 8'h3E;
	localparam logic [7:0] CHAR_PRINT_LO  = 8'h21;
	localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;

	// 2-bit base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// configuration register file
	localparam int         CFG_ADDR_W   = 3;
	localparam int         BAND_W       = 16;
	localparam logic       REG_BAND     = 1'b0;
	localparam logic [BAND_W-1:0] BAND_RESET = 16'd10;

	// result buffer
	localparam int RB_DEPTH = 4;
	localparam int RB_PTR_W = $clog2(RB_DEPTH);
	localparam int RB_CNT_W = $clog2(RB_DEPTH + 1);

	// one result transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  base_code;
		logic [31:0] piece_number;
		logic [31:0] piece_lead_unknown;
		logic [31:0] piece_body_len;
		logic [31:0] seq_len;
		logic [31:0] total_a;
		logic [31:0] total_c;
		logic [31:0] total_g;
		logic [31:0] total_t;
		logic [31:0] total_unknown;
		logic        last;
	} res_t;

	// results produced by one accepted item
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

`default_nettype wire

FILE: rtl/nsps_in_if.sv
// ----------------------------------------------------------------------------
// nsps_in_if
// Character channel: valid/ready handshake with one sequence character.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsps_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] char_byte;
	logic [1:0] fill_code;

	modport source(output valid, action, char_byte, fill_code, input ready);
	modport sink(input valid, action, char_byte, fill_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/nsps_out_if.sv
// ----------------------------------------------------------------------------
// nsps_out_if
// Result channel: valid/ready handshake with one base, piece or summary.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  base_code;
	logic [31:0] piece_number;
	logic [31:0] piece_lead_unknown;
	logic [31:0] piece_body_len;
	logic [31:0] seq_len;
	logic [31:0] total_a;
	logic [31:0] total_c;
	logic [31:0] total_g;
	logic [31:0] total_t;
	logic [31:0] total_unknown;
	logic        last;

	modport source(output valid, kind, base_code, piece_number, piece_lead_unknown,
		piece_body_len, seq_len, total_a, total_c, total_g, total_t, total_unknown,
		last, input ready);
	modport sink(input valid, kind, base_code, piece_number, piece_lead_unknown,
		piece_body_len, seq_len, total_a, total_c, total_g, total_t, total_unknown,
		last, output ready);
endinterface

`default_nettype wire

FILE: rtl/nsps_cfg.sv
// ----------------------------------------------------------------------------
// nsps_cfg
// APB register slave holding the unknown-run band.
// ----------------------------------------------------------------------------
`default_nettype none

module nsps_cfg import nsps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output logic      [BAND_W-1:0]     band
);

	logic [BAND_W-1:0] band_q;
	logic              wr_band;

	// access phase write to the band register
	assign wr_band = psel && penable && pwrite && (paddr[2] == REG_BAND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= BAND_RESET;
		end else if (wr_band) begin
			band_q <= pwdata[BAND_W-1:0];
		end
	end

	// read back, unmapped addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BAND) begin
			prdata = {{(32-BAND_W){1'b0}}, band_q};
		end
	end

	assign pready = 1'b1;
	assign band   = band_q;

endmodule

`default_nettype wire

FILE: rtl/nsps_core.sv
// ----------------------------------------------------------------------------
// nsps_core
// Per-character classification, piece bookkeeping and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module nsps_core import nsps_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	nsps_in_if.sink          in,
	input  wire logic        room,
	input  wire logic [BAND_W-1:0] band,
	output push_t            push
);

	localparam int CW = COUNT_WIDTH;

	logic [CW-1:0] lead_q, body_q, run_q, idx_q, seq_len_q;
	logic          prev_unk_q;
	logic [CW-1:0] cnt_q [5];

	logic [CW-1:0] lead_d, body_d, run_d, idx_d, seq_len_d;
	logic          prev_unk_d;
	logic [4:0]    cnt_inc;

	logic          accept, is_end, printable, known;
	logic [1:0]    known_code;
	logic [CW-1:0] run_inc;

	// empty result with only the kind set
	function automatic res_t res_blank(input logic [1:0] kind);
		res_t r;
		r      = '0;
		r.kind = kind;
		return r;
	endfunction

	assign accept = in.valid && in.ready;
	assign in.ready = room;

	// character classes
	assign is_end    = (in.action == ACT_END) || (in.char_byte == CHAR_HEADER);
	assign printable = (in.char_byte >= CHAR_PRINT_LO) && (in.char_byte <= CHAR_PRINT_HI);

	always_comb begin
		known      = 1'b1;
		known_code = BASE_A;
		case (in.char_byte)
			"A", "a": known_code = BASE_A;
			"C", "c": known_code = BASE_C;
			"G", "g": known_code = BASE_G;
			"T", "t": known_code = BASE_T;
			default:  known = 1'b0;
		endcase
	end

	assign run_inc = prev_unk_q ? run_q + 1'b1 : run_q;

	// next state and results for the accepted item
	always_comb begin
		lead_d     = lead_q;
		body_d     = body_q;
		run_d      = run_q;
		idx_d      = idx_q;
		seq_len_d  = seq_len_q;
		prev_unk_d = prev_unk_q;
		cnt_inc    = '0;
		push       = '0;
		if (accept) begin
			if (is_end) begin
				push.n                     = 2'd2;
				push.r0                    = res_blank(KIND_PIECE);
				push.r0.piece_number       = 32'(idx_q);
				push.r0.piece_lead_unknown = 32'(lead_q);
				push.r0.piece_body_len     = 32'(body_q);
				push.r1                    = res_blank(KIND_SUMMARY);
				push.r1.seq_len            = 32'(seq_len_q);
				push.r1.total_a            = 32'(cnt_q[0]);
				push.r1.total_c            = 32'(cnt_q[1]);
				push.r1.total_g            = 32'(cnt_q[2]);
				push.r1.total_t            = 32'(cnt_q[3]);
				push.r1.total_unknown      = 32'(cnt_q[4]);
				push.r1.last               = 1'b1;
				lead_d     = '0;
				body_d     = '0;
				run_d      = '0;
				idx_d      = '0;
				seq_len_d  = '0;
				prev_unk_d = 1'b1;
			end else if (printable) begin
				seq_len_d       = seq_len_q + 1'b1;
				push.n          = 2'd1;
				push.r0         = res_blank(KIND_BASE);
				push.r0.last    = 1'b1;
				if (known) begin
					push.r0.base_code   = known_code;
					run_d               = '0;
					prev_unk_d          = 1'b0;
					body_d              = body_q + 1'b1;
					cnt_inc[known_code] = 1'b1;
				end else begin
					push.r0.base_code = in.fill_code;
					run_d             = run_inc;
					prev_unk_d        = 1'b1;
					cnt_inc[4]        = 1'b1;
					if (body_q == '0) begin
						lead_d = lead_q + 1'b1;
					end else if (run_inc >= CW'(band)) begin
						// long unknown run closes the current piece
						push.n                     = 2'd2;
						push.r0.last               = 1'b0;
						push.r1                    = res_blank(KIND_PIECE);
						push.r1.piece_number       = 32'(idx_q);
						push.r1.piece_lead_unknown = 32'(lead_q);
						push.r1.piece_body_len     = 32'(body_q);
						push.r1.last               = 1'b1;
						run_d  = CW'(1);
						idx_d  = idx_q + 1'b1;
						lead_d = CW'(1);
						body_d = '0;
					end else begin
						body_d = body_q + 1'b1;
					end
				end
			end
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= '0;
			body_q     <= '0;
			run_q      <= '0;
			idx_q      <= '0;
			seq_len_q  <= '0;
			prev_unk_q <= 1'b1;
		end else begin
			lead_q     <= lead_d;
			body_q     <= body_d;
			run_q      <= run_d;
			idx_q      <= idx_d;
			seq_len_q  <= seq_len_d;
			prev_unk_q <= prev_unk_d;
		end
	end

	// running base counts, kept across sequences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 5; i++) begin
				if (cnt_inc[i]) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_summary_last, (push.n == 2'd2 && push.r1.kind == KIND_SUMMARY) |-> push.r1.last, "summary not marked last")
	`ASSERT_NEXT(a_end_clears, accept && is_end, seq_len_q == '0 && body_q == '0 && prev_unk_q, "sequence state not cleared after end")
	`ASSERT_CLK(a_body_lead, (accept && printable && !is_end && !known && body_q == '0) |-> push.n == 2'd1, "piece split with empty body")

endmodule

`default_nettype wire

FILE: rtl/nsps_rbuf.sv
// ----------------------------------------------------------------------------
// nsps_rbuf
// Four-entry result buffer taking up to two results a cycle, one out.
// ----------------------------------------------------------------------------
`default_nettype none

module nsps_rbuf import nsps_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  push_t     push,
	output logic      room,
	nsps_out_if.source out
);

	res_t                ent_q [RB_DEPTH];
	logic [RB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RB_CNT_W-1:0] cnt_q;
	logic                pop;
	res_t                head;

	// space for the worst case of two results
	assign room = (cnt_q <= RB_CNT_W'(RB_DEPTH - 2));
	assign pop  = out.valid && out.ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[wr_ptr_q + 1'b1] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RB_PTR_W'(push.n);
			rd_ptr_q <= rd_ptr_q + RB_PTR_W'(pop);
			cnt_q    <= cnt_q + RB_CNT_W'(push.n) - RB_CNT_W'(pop);
		end
	end

	// head entry drives the result channel
	assign head                   = ent_q[rd_ptr_q];
	assign out.valid              = (cnt_q != '0);
	assign out.kind               = head.kind;
	assign out.base_code          = head.base_code;
	assign out.piece_number       = head.piece_number;
	assign out.piece_lead_unknown = head.piece_lead_unknown;
	assign out.piece_body_len     = head.piece_body_len;
	assign out.seq_len            = head.seq_len;
	assign out.total_a            = head.total_a;
	assign out.total_c            = head.total_c;
	assign out.total_g            = head.total_g;
	assign out.total_t            = head.total_t;
	assign out.total_unknown      = head.total_unknown;
	assign out.last               = head.last;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_cnt_max, cnt_q <= RB_CNT_W'(RB_DEPTH), "result buffer overflow")
	`ASSERT_CLK(a_push_room, (push.n != 2'd0) |-> room, "results pushed without room")
	`ASSERT_NEXT(a_stall_keeps, out.valid && !out.ready, cnt_q >= $past(cnt_q), "results lost while stalled")

endmodule

`default_nettype wire

FILE: rtl/nucleotide_stream_packer_segmenter_unit.sv
// ----------------------------------------------------------------------------
// nucleotide_stream_packer_segmenter_unit
// Packs sequence characters into 2-bit bases and cuts pieces at unknown runs.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one character transaction per cycle while in.ready is high (action, char_byte, fill_code).
//         A '>' byte or action end closes the sequence.
//   out : base, closed piece record or sequence summary; last marks the final
//         result of an input transaction.
//   APB : register 0 at address 0 holds the unknown-run band (reset 10).
// Results: each result is registered in the result buffer and presented on out from its head entry.
// Throughput: one character per cycle. A character or end that yields two
//   results takes two output slots; the four-entry result buffer accepts a
//   new input whenever at least two slots are free, so input stalls only
//   when the receiver holds out.ready low or two-result items pile up.
// Ignored bytes (outside 0x21..0x7E) are accepted and give no result.
// Reset: clears all counters and the result buffer; the band returns to 10.
// Receiver stall: results wait in the buffer; in.ready drops once fewer than
//   two slots remain, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module nucleotide_stream_packer_segmenter_unit import nsps_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	nsps_in_if.sink                    in,
	nsps_out_if.source                 out,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	logic [BAND_W-1:0] band;
	logic              room;
	push_t             push;

	// configuration register
	nsps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.band    (band)
	);

	// classification and piece state
	nsps_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.room   (room),
		.band   (band),
		.push   (push)
	);

	// result buffer
	nsps_rbuf u_rbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out    (out)
	);

endmodule

`default_nettype wire

FILE: test/nucleotide_stream_packer_segmenter_unit_tb.sv
// ----------------------------------------------------------------------------
// nucleotide_stream_packer_segmenter_unit_tb
// Drives sequence characters, end items and band settings into the packer and
// checks every base, piece record and summary against a cycle-free predictor
// of the packing and piece-cutting rules, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module nucleotide_stream_packer_segmenter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nsps_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 3;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 230;
	localparam int UNKNOWN_SLOT   = 4;

	localparam logic [CFG_ADDR_W-1:0] BAND_ADDR = CFG_ADDR_W'(4 * int'(REG_BAND));
	localparam logic [7:0] KNOWN_CHARS [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

	typedef enum int {PH_PLAIN, PH_RX_HOLD, PH_TX_DRAIN} phase_twist_t;

	// one row of the directed table; typed_n < 0 means the predictor decides
	typedef struct {
		logic       act;
		logic [7:0] chr;
		logic [1:0] fill;
		int         typed_n;
		res_t       e0;
		res_t       e1;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	nsps_in_if  in_ch();
	nsps_out_if out_ch();

	nucleotide_stream_packer_segmenter_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in      (in_ch),
		.out     (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	logic [BAND_W-1:0] band_cfg;
	logic [31:0] lead_unk;
	logic [31:0] body_len;
	logic [31:0] unk_run;
	logic        prev_unk;
	logic [31:0] piece_idx;
	logic [31:0] seq_bases;
	logic [31:0] base_tally [5];

	res_t predicted_out[$];
	dir_row_t directed_rows[$];

	int  mismatches = 0;
	int  sent = 0;
	int  stall_cycles = 0;
	bit  tx_steady = 1'b0;
	bit  hold_off_request = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// result records
	function automatic res_t base_rec(logic [1:0] code, logic last);
		res_t r;
		r = '0;
		r.kind = KIND_BASE;
		r.base_code = code;
		r.last = last;
		return r;
	endfunction

	function automatic res_t piece_rec(logic [31:0] num, logic [31:0] lead, logic [31:0] body,
			logic last);
		res_t r;
		r = '0;
		r.kind = KIND_PIECE;
		r.piece_number = num;
		r.piece_lead_unknown = lead;
		r.piece_body_len = body;
		r.last = last;
		return r;
	endfunction

	function automatic res_t summary_rec(logic [31:0] len, logic [31:0] a, logic [31:0] c,
			logic [31:0] g, logic [31:0] t, logic [31:0] u);
		res_t r;
		r = '0;
		r.kind = KIND_SUMMARY;
		r.seq_len = len;
		r.total_a = a;
		r.total_c = c;
		r.total_g = g;
		r.total_t = t;
		r.total_unknown = u;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic dir_row_t row(logic act, logic [7:0] chr, logic [1:0] fill, int typed_n,
			res_t e0, res_t e1);
		dir_row_t d;
		d.act = act;
		d.chr = chr;
		d.fill = fill;
		d.typed_n = typed_n;
		d.e0 = e0;
		d.e1 = e1;
		return d;
	endfunction

	function automatic bit known_base(input logic [7:0] chr, output logic [1:0] code);
		code = BASE_A;
		case (chr)
			"A", "a": code = BASE_A;
			"C", "c": code = BASE_C;
			"G", "g": code = BASE_G;
			"T", "t": code = BASE_T;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// per-sequence counters back to their start values
	function automatic void clear_sequence();
		lead_unk = '0;
		body_len = '0;
		unk_run = '0;
		prev_unk = 1'b1;
		piece_idx = '0;
		seq_bases = '0;
	endfunction

	// packs one character, cuts pieces, returns how many results it queued
	function automatic int segment_char(logic act, logic [7:0] chr, logic [1:0] fill);
		logic [1:0] code;
		if (act == ACT_END || chr == CHAR_HEADER) begin
			predicted_out.push_back(piece_rec(piece_idx, lead_unk, body_len, 1'b0));
			predicted_out.push_back(summary_rec(seq_bases, base_tally[0], base_tally[1],
				base_tally[2], base_tally[3], base_tally[UNKNOWN_SLOT]));
			clear_sequence();
			return 2;
		end
		if (chr < CHAR_PRINT_LO || chr > CHAR_PRINT_HI)
			return 0;
		seq_bases++;
		if (known_base(chr, code)) begin
			unk_run = '0;
			prev_unk = 1'b0;
			body_len++;
			base_tally[code]++;
			predicted_out.push_back(base_rec(code, 1'b1));
			return 1;
		end
		// unknown base, replaced by the fill code
		if (prev_unk)
			unk_run++;
		prev_unk = 1'b1;
		base_tally[UNKNOWN_SLOT]++;
		if (body_len == 0) begin
			lead_unk++;
		end else if (unk_run >= {16'b0, band_cfg}) begin
			predicted_out.push_back(base_rec(fill, 1'b0));
			predicted_out.push_back(piece_rec(piece_idx, lead_unk, body_len, 1'b1));
			unk_run = 32'd1;
			piece_idx++;
			lead_unk = 32'd1;
			body_len = '0;
			return 2;
		end else begin
			body_len++;
		end
		predicted_out.push_back(base_rec(fill, 1'b1));
		return 1;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// result monitor
	always @(posedge clk) begin : result_monitor
		res_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (predicted_out.size() == 0) begin
				$error("kind: expected no result, got %0h", out_ch.kind);
				mismatches++;
			end else begin
				want = predicted_out.pop_front();
				check_field("kind", want.kind, out_ch.kind);
				check_field("base_code", want.base_code, out_ch.base_code);
				check_field("piece_number", want.piece_number, out_ch.piece_number);
				check_field("piece_lead_unknown", want.piece_lead_unknown,
					out_ch.piece_lead_unknown);
				check_field("piece_body_len", want.piece_body_len, out_ch.piece_body_len);
				check_field("seq_len", want.seq_len, out_ch.seq_len);
				check_field("total_a", want.total_a, out_ch.total_a);
				check_field("total_c", want.total_c, out_ch.total_c);
				check_field("total_g", want.total_g, out_ch.total_g);
				check_field("total_t", want.total_t, out_ch.total_t);
				check_field("total_unknown", want.total_unknown, out_ch.total_unknown);
				check_field("last", want.last, out_ch.last);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver: random gaps, steady stretches and a long hold when asked
	initial begin : receiver
		int rx_wait;
		int rx_run;
		int r;
		rx_wait = 0;
		rx_run = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_request = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (rx_wait > 0) begin
				out_ch.ready <= 1'b0;
				rx_wait--;
			end else begin
				out_ch.ready <= 1'b1;
				if (rx_run > 0) begin
					rx_run--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 5)
						rx_run = $urandom_range(20, 80);
					else if (r < 60)
						rx_wait = 0;
					else if (r < 95)
						rx_wait = $urandom_range(1, 3);
					else
						rx_wait = $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (tx_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_unknown();
		logic [1:0] code;
		logic [7:0] c;
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(0, 1) ? "N" : "n";
		do
			c = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
		while (known_base(c, code) || c == CHAR_HEADER);
		return c;
	endfunction

	// unknown runs sized around the band, when it is at most 16, so that pieces get cut
	function automatic int unknown_run_len();
		if (band_cfg <= 16)
			return $urandom_range(1, int'(band_cfg) + 2);
		return $urandom_range(1, 4);
	endfunction

	// offers one character transaction and waits for it to be taken
	task automatic send_item(input logic act, input logic [7:0] chr, input logic [1:0] fill,
			output int n_made);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.char_byte <= chr;
		in_ch.fill_code <= fill;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		n_made = segment_char(act, chr, fill);
	endtask

	task automatic tx_pause(int n);
		if (n == 0)
			return;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic feed(logic act, logic [7:0] chr, logic [1:0] fill);
		int n;
		send_item(act, chr, fill, n);
		if (act == ACT_END || (chr >= CHAR_PRINT_LO && chr <= CHAR_PRINT_HI))
			sent++;
		tx_pause(pick_gap());
	endtask

	// a character, sometimes after a line break the block skips
	task automatic feed_char(logic [7:0] chr);
		if ($urandom_range(0, 11) == 0)
			feed(ACT_CHAR, $urandom_range(0, 1) ? 8'h0A : 8'h0D, 2'($urandom));
		feed(ACT_CHAR, chr, 2'($urandom));
	endtask

	// well-formed sequence: known and unknown runs, closed by an end or a header
	task automatic send_sequence();
		int len;
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1)) begin
				len = $urandom_range(1, 12);
				repeat (len) feed_char(KNOWN_CHARS[$urandom_range(0, 7)]);
			end else begin
				len = unknown_run_len();
				repeat (len) feed_char(pick_unknown());
			end
		end
		if ($urandom_range(0, 1))
			feed(ACT_END, 8'($urandom), 2'($urandom));
		else
			feed(ACT_CHAR, CHAR_HEADER, 2'($urandom));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(4, 16))
			feed(($urandom_range(0, 15) == 0) ? ACT_END : ACT_CHAR, 8'($urandom), 2'($urandom));
	endtask

	// sender idle until every predicted result has come out
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (predicted_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr, output logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// band write with random upper bits, then read back
	task automatic write_band(logic [BAND_W-1:0] value);
		logic [31:0] word;
		logic [31:0] got;
		word = $urandom;
		word[BAND_W-1:0] = value;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= BAND_ADDR;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		band_cfg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apb_read(BAND_ADDR, got);
		check_field("unknown_run_band", value, got[BAND_W-1:0]);
	endtask

	task automatic run_phase(phase_twist_t twist);
		int goal;
		bit twisted;
		goal = sent + PHASE_ITEMS;
		twisted = 1'b0;
		while (sent < goal) begin
			if (!twisted && sent >= goal - PHASE_ITEMS / 2) begin
				twisted = 1'b1;
				if (twist == PH_RX_HOLD)
					hold_off_request = 1'b1;
				else if (twist == PH_TX_DRAIN)
					wait_drained();
			end
			tx_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 85)
				send_sequence();
			else
				send_noise();
		end
	endtask

	// main stimulus
	initial begin : stimulus
		int n_made;
		logic [31:0] got;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_CHAR;
		in_ch.char_byte = 8'h00;
		in_ch.fill_code = 2'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		band_cfg = BAND_RESET;
		clear_sequence();
		foreach (base_tally[i])
			base_tally[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_read(BAND_ADDR, got);
		check_field("unknown_run_band", BAND_RESET, got[BAND_W-1:0]);

		// empty sequence right after reset: zero record and zero summary
		directed_rows.push_back(row(ACT_END, 8'h00, 2'd0, 2,
			piece_rec(32'd0, 32'd0, 32'd0, 1'b0), summary_rec(0, 0, 0, 0, 0, 0)));
		// known bases in both cases
		directed_rows.push_back(row(ACT_CHAR, "A", 2'd3, 1, base_rec(BASE_A, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "c", 2'd0, 1, base_rec(BASE_C, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "G", 2'd1, 1, base_rec(BASE_G, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "t", 2'd2, 1, base_rec(BASE_T, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "a", 2'd1, 1, base_rec(BASE_A, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "C", 2'd2, 1, base_rec(BASE_C, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "g", 2'd3, 1, base_rec(BASE_G, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "T", 2'd0, 1, base_rec(BASE_T, 1'b1), '0));
		// bytes outside the printable range give nothing
		directed_rows.push_back(row(ACT_CHAR, 8'h00, 2'd3, 0, '0, '0));
		directed_rows.push_back(row(ACT_CHAR, 8'h20, 2'd3, 0, '0, '0));
		directed_rows.push_back(row(ACT_CHAR, 8'h7F, 2'd3, 0, '0, '0));
		directed_rows.push_back(row(ACT_CHAR, 8'hFF, 2'd3, 0, '0, '0));
		directed_rows.push_back(row(ACT_CHAR, 8'h0A, 2'd3, 0, '0, '0));
		// unknown bases in the body come out as the fill code
		directed_rows.push_back(row(ACT_CHAR, 8'h21, 2'd3, 1, base_rec(BASE_T, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, 8'h7E, 2'd0, 1, base_rec(BASE_A, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "N", 2'd2, 1, base_rec(BASE_G, 1'b1), '0));
		directed_rows.push_back(row(ACT_CHAR, "n", 2'd1, 1, base_rec(BASE_C, 1'b1), '0));
		// header marker closes the sequence like an end item
		directed_rows.push_back(row(ACT_CHAR, CHAR_HEADER, 2'd2, -1, '0, '0));
		// leading unknown bases of a fresh sequence
		directed_rows.push_back(row(ACT_CHAR, "N", 2'd0, -1, '0, '0));
		directed_rows.push_back(row(ACT_CHAR, "x", 2'd3, -1, '0, '0));
		directed_rows.push_back(row(ACT_CHAR, "-", 2'd1, -1, '0, '0));
		directed_rows.push_back(row(ACT_CHAR, "g", 2'd2, -1, '0, '0));
		// end item carrying a base byte: the byte is not looked at
		directed_rows.push_back(row(ACT_END, "A", 2'd3, -1, '0, '0));

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].act, directed_rows[i].chr, directed_rows[i].fill, n_made);
			// typed rows replace what the predictor queued for them
			if (directed_rows[i].typed_n >= 0) begin
				repeat (n_made) void'(predicted_out.pop_back());
				if (directed_rows[i].typed_n > 0)
					predicted_out.push_back(directed_rows[i].e0);
				if (directed_rows[i].typed_n > 1)
					predicted_out.push_back(directed_rows[i].e1);
			end
			tx_pause(pick_gap());
		end

		// random phases over several band settings
		wait_drained();
		run_phase(PH_PLAIN);
		wait_drained();
		write_band(16'd1);
		run_phase(PH_RX_HOLD);
		wait_drained();
		write_band(16'd0);
		run_phase(PH_PLAIN);
		wait_drained();
		write_band(16'hFFFF);
		run_phase(PH_TX_DRAIN);
		wait_drained();
		write_band(16'($urandom_range(2, 16)));
		run_phase(PH_RX_HOLD);
		wait_drained();
		write_band(16'd3);
		run_phase(PH_PLAIN);
		wait_drained();
		write_band(BAND_RESET);
		run_phase(PH_TX_DRAIN);
		wait_drained();

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
